// File: hw/rtl/ksfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksfp_pkg
// Shared types and constants of the knob scanner with freeze and pickup.
// ----------------------------------------------------------------------------
package ksfp_pkg;

    localparam int CHANNELS_DEF = 6;   // default knob count
    localparam int MAX_CH       = 8;   // largest knob count, width of flag vectors
    localparam int MASK_W       = 6;   // knobs reported in the masks
    localparam int KIND_W       = 3;
    localparam int SAMPLE_W     = 10;
    localparam int INDEX_W      = 3;
    localparam int VALUE_W      = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE        = 3'd0,
        KIND_FREEZE_VALUE  = 3'd1,
        KIND_FREEZE        = 3'd2,
        KIND_FREEZE_ALL    = 3'd3,
        KIND_UNFREEZE      = 3'd4,
        KIND_QUERY         = 3'd5
    } kind_t;

    // one memory entry per knob
    typedef struct packed {
        logic [VALUE_W-1:0] pickup;
        logic [VALUE_W-1:0] knob;
    } knob_entry_t;

endpackage

// File: hw/rtl/ksfp_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksfp_item_if
// Request channel: sample or command item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ksfp_item_if;

    logic                         valid;
    logic                         ready;
    logic [ksfp_pkg::KIND_W-1:0]   kind;
    logic [ksfp_pkg::SAMPLE_W-1:0] adc_sample;
    logic [ksfp_pkg::INDEX_W-1:0]  knob_index;
    logic [ksfp_pkg::VALUE_W-1:0]  freeze_value;

    modport source (output valid, kind, adc_sample, knob_index, freeze_value, input ready);
    modport sink   (input valid, kind, adc_sample, knob_index, freeze_value, output ready);

endinterface

// File: hw/rtl/ksfp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksfp_result_if
// Result channel: per-knob status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ksfp_result_if;

    logic                        valid;
    logic                        ready;
    logic [ksfp_pkg::INDEX_W-1:0] channel;
    logic [ksfp_pkg::VALUE_W-1:0] knob_value;
    logic                        moved;
    logic                        frozen;
    logic [ksfp_pkg::MASK_W-1:0]  moved_mask;
    logic [ksfp_pkg::MASK_W-1:0]  frozen_mask;

    modport source (output valid, channel, knob_value, moved, frozen, moved_mask,
                    frozen_mask, input ready);
    modport sink   (input valid, channel, knob_value, moved, frozen, moved_mask,
                    frozen_mask, output ready);

endinterface

// File: hw/rtl/knob_scan_freeze_pickup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_scan_freeze_pickup_unit
// Round-robin knob scanner with moved detection, freeze and pickup.
// ----------------------------------------------------------------------------
// Takes one request per clock when not stalled and returns one result per
// request, through the synchronous knob memory read and then the output
// register. Knob and pickup values live in a CHANNELS-deep memory read at
// acceptance and written back as the request leaves the middle stage; a
// one-entry bypass register covers a read that lands on the entry being
// written. Moved and frozen flags, the scan channel and the tolerance are
// plain registers. The output register decouples the sides, so a new
// request is taken while a result waits, as long as the result is taken in
// the same cycle or the middle stage is empty. Memory entries never written
// read as zero via per-entry valid bits cleared at reset.
module knob_scan_freeze_pickup_unit #(
    parameter int CHANNELS = ksfp_pkg::CHANNELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [ksfp_pkg::VALUE_W-1:0] cfg_wr_data,
    ksfp_item_if.sink                    item,
    ksfp_result_if.source                result
);
    import ksfp_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [MAX_CH-1:0] ALL_MASK = MAX_CH'((1 << CHANNELS) - 1);

    // configuration and control state
    logic [VALUE_W-1:0]  tol_reg;
    logic [CH_W-1:0]     scan_reg;
    logic [MAX_CH-1:0]   frozen_reg, frozen_next;
    logic [MAX_CH-1:0]   moved_reg, moved_next;
    logic [CHANNELS-1:0] entry_valid_reg;

    // knob memory
    knob_entry_t         mem [CHANNELS];
    knob_entry_t         rd_data_reg;
    knob_entry_t         wr_data;
    logic                wr_en;

    // bypass of the last write
    logic                byp_valid_reg;
    logic [CH_W-1:0]     byp_addr_reg;
    knob_entry_t         byp_data_reg;

    // middle stage
    logic                s1_valid_reg;
    kind_t               s1_kind_reg;
    logic [VALUE_W-1:0]  s1_nv_reg;
    logic [INDEX_W-1:0]  s1_idx_reg;
    logic [VALUE_W-1:0]  s1_fval_reg;
    logic [CH_W-1:0]     s1_addr_reg;
    logic                s1_ok_reg;

    // output register
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_channel_reg;
    logic [VALUE_W-1:0]  out_knob_reg;
    logic                out_moved_reg;
    logic                out_frozen_reg;
    logic [MASK_W-1:0]   out_moved_mask_reg;
    logic [MASK_W-1:0]   out_frozen_mask_reg;

    logic                accept;
    logic                s1_adv;
    logic                in_is_sample;
    logic                in_ok;
    logic [CH_W-1:0]     rd_addr;

    knob_entry_t         cur;
    logic [VALUE_W-1:0]  diff;
    logic [VALUE_W-1:0]  lo_val;
    logic [VALUE_W-1:0]  hi_val;
    logic [MAX_CH-1:0]   bit_sel;
    logic [INDEX_W-1:0]  res_channel;
    logic [INDEX_W-1:0]  flag_idx;
    logic [VALUE_W-1:0]  res_knob;
    logic                res_ok;

    assign s1_adv       = !out_valid_reg || result.ready;
    assign item.ready   = !s1_valid_reg || s1_adv;
    assign accept       = item.valid && item.ready;
    assign in_is_sample = (item.kind == KIND_SAMPLE);
    assign in_ok        = (32'(item.knob_index) < CHANNELS);
    assign rd_addr      = in_is_sample ? scan_reg
                        : (in_ok ? item.knob_index[CH_W-1:0] : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= VALUE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    // memory read port
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= wr_data;
        end
    end

    // stage 1: merge the read data with the bypass and update the entry
    always_comb
    begin
        if (byp_valid_reg && byp_addr_reg == s1_addr_reg)
        begin
            cur = byp_data_reg;
        end
        else if (entry_valid_reg[s1_addr_reg])
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end

        diff        = (cur.knob > s1_nv_reg) ? (cur.knob - s1_nv_reg) : (s1_nv_reg - cur.knob);
        lo_val      = (cur.knob > s1_nv_reg) ? s1_nv_reg : cur.knob;
        hi_val      = (cur.knob > s1_nv_reg) ? cur.knob : s1_nv_reg;
        bit_sel     = MAX_CH'(1) << s1_addr_reg;
        frozen_next = frozen_reg;
        moved_next  = moved_reg;
        wr_en       = 1'b0;
        wr_data     = cur;
        res_ok      = s1_ok_reg;
        res_channel = s1_idx_reg;
        res_knob    = cur.knob;

        case (s1_kind_reg)
            KIND_SAMPLE:
            begin
                wr_en        = 1'b1;
                wr_data.knob = s1_nv_reg;
                res_ok       = 1'b1;
                res_channel  = INDEX_W'(s1_addr_reg);
                res_knob     = s1_nv_reg;
                if (diff > tol_reg)
                begin
                    moved_next  = moved_reg | bit_sel;
                    frozen_next = frozen_reg & ~bit_sel;
                end
                else
                begin
                    moved_next = moved_reg & ~bit_sel;
                end
                // pickup: pickup value crossed or touched
                if (cur.pickup >= lo_val && cur.pickup <= hi_val)
                begin
                    frozen_next = frozen_next & ~bit_sel;
                end
            end
            KIND_FREEZE_VALUE:
            begin
                if (s1_ok_reg)
                begin
                    wr_en          = 1'b1;
                    wr_data.pickup = s1_fval_reg;
                    frozen_next    = frozen_reg | bit_sel;
                end
            end
            KIND_FREEZE:
            begin
                if (s1_ok_reg)
                begin
                    frozen_next = frozen_reg | bit_sel;
                end
            end
            KIND_FREEZE_ALL:
            begin
                frozen_next = ALL_MASK;
            end
            KIND_UNFREEZE:
            begin
                if (s1_ok_reg)
                begin
                    frozen_next = frozen_reg & ~bit_sel;
                end
            end
            default:
            begin
            end
        endcase

        wr_en    = wr_en && s1_valid_reg && s1_adv;
        flag_idx = res_channel;
        if (!res_ok)
        begin
            res_knob = '0;
        end
        frozen_next = frozen_next & ALL_MASK;
        moved_next  = moved_next & ALL_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg        <= '0;
            frozen_reg      <= ALL_MASK;
            moved_reg       <= '0;
            entry_valid_reg <= '0;
            byp_valid_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept && in_is_sample)
            begin
                scan_reg <= (scan_reg == CH_W'(CHANNELS - 1)) ? '0 : scan_reg + CH_W'(1);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_valid_reg && s1_adv)
            begin
                frozen_reg    <= frozen_next;
                moved_reg     <= moved_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                entry_valid_reg[s1_addr_reg] <= 1'b1;
                byp_valid_reg                <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind_t'(item.kind);
            s1_nv_reg   <= item.adc_sample[SAMPLE_W-1:SAMPLE_W-VALUE_W];
            s1_idx_reg  <= item.knob_index;
            s1_fval_reg <= item.freeze_value;
            s1_addr_reg <= rd_addr;
            s1_ok_reg   <= in_ok;
        end
        if (wr_en)
        begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= wr_data;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_channel_reg     <= res_channel;
            out_knob_reg        <= res_knob;
            out_moved_reg       <= res_ok && moved_next[flag_idx];
            out_frozen_reg      <= res_ok && frozen_next[flag_idx];
            out_moved_mask_reg  <= moved_next[MASK_W-1:0];
            out_frozen_mask_reg <= frozen_next[MASK_W-1:0];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.channel     = out_channel_reg;
    assign result.knob_value  = out_knob_reg;
    assign result.moved       = out_moved_reg;
    assign result.frozen      = out_frozen_reg;
    assign result.moved_mask  = out_moved_mask_reg;
    assign result.frozen_mask = out_frozen_mask_reg;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the knob scanner with freeze and pickup. A directed
// table covers reset state, field extremes and out-of-range knobs, then random
// sample/command traffic runs under several tolerance settings with random
// stalls on both channels. Each result is checked against a model or table row.
// ----------------------------------------------------------------------------
module testbench;

    import ksfp_pkg::*;

    localparam int KNOBS        = CHANNELS_DEF;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int LONG_HOLD    = 300;   // receiver back-pressure stretch
    localparam int TAIL_CYCLES  = 6;
    localparam int BURST_ITEMS  = 280;
    localparam int PRINT_CAP    = 40;

    // kinds the block treats as a query
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SAMPLE_W-1:0] adc_sample;
        logic [INDEX_W-1:0]  knob_index;
        logic [VALUE_W-1:0]  freeze_value;
    } knob_request_t;

    typedef struct packed {
        logic [INDEX_W-1:0] channel;
        logic [VALUE_W-1:0] knob_value;
        logic               moved;
        logic               frozen;
        logic [MASK_W-1:0]  moved_mask;
        logic [MASK_W-1:0]  frozen_mask;
    } knob_status_t;

    typedef struct packed {
        knob_request_t req;
        logic          known;
        knob_status_t  want;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [VALUE_W-1:0] cfg_wr_data;

    ksfp_item_if   item_ch ();
    ksfp_result_if result_ch ();

    knob_scan_freeze_pickup_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // model state
    logic [VALUE_W-1:0] knob_mem   [KNOBS];
    logic [VALUE_W-1:0] pickup_mem [KNOBS];
    logic [KNOBS-1:0]   frozen_bits;
    logic [KNOBS-1:0]   moved_bits;
    logic [INDEX_W-1:0] scan_pos;
    logic [VALUE_W-1:0] tolerance_model;

    knob_status_t pending_status [$];
    table_row_t   directed_rows [$];

    // side info of the request currently offered; fixed rows carry a typed result
    logic         offered_known;
    knob_status_t offered_fixed;

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    logic hold_req;

    // stimulus-side tracking of the knobs, for samples near the last value
    logic [VALUE_W-1:0] walk [KNOBS];
    int                 gen_scan = 0;

    knob_status_t  seen_status;
    knob_status_t  want_status;
    knob_request_t taken_req;
    bit            any_handshake;

    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic knob_status_t make_status(input int ch, input int val, input int mv,
                                                 input int fz, input int mm, input int fm);
        knob_status_t s;
        s.channel     = ch[INDEX_W-1:0];
        s.knob_value  = val[VALUE_W-1:0];
        s.moved       = mv[0];
        s.frozen      = fz[0];
        s.moved_mask  = mm[MASK_W-1:0];
        s.frozen_mask = fm[MASK_W-1:0];
        return s;
    endfunction

    function automatic knob_status_t apply_request(input knob_request_t r);
        knob_status_t       s;
        logic [INDEX_W-1:0] ch;
        logic [VALUE_W-1:0] old_v;
        logic [VALUE_W-1:0] new_v;
        logic [VALUE_W-1:0] diff;
        logic [VALUE_W-1:0] p;
        bit                 idx_ok;
        s      = '0;
        idx_ok = r.knob_index < KNOBS;
        if (r.kind == KIND_SAMPLE)
        begin
            ch    = scan_pos;
            old_v = knob_mem[ch];
            new_v = r.adc_sample[SAMPLE_W-1:2];
            diff  = (old_v > new_v) ? old_v - new_v : new_v - old_v;
            knob_mem[ch] = new_v;
            if (diff > tolerance_model)
            begin
                moved_bits[ch]  = 1'b1;
                frozen_bits[ch] = 1'b0;
            end
            else
            begin
                moved_bits[ch] = 1'b0;
            end
            // pickup: knob passed over (or sits on) the frozen value
            p = pickup_mem[ch];
            if ((p <= old_v && p >= new_v) || (p >= old_v && p <= new_v))
            begin
                frozen_bits[ch] = 1'b0;
            end
            scan_pos = (ch == KNOBS - 1) ? '0 : ch + 1'b1;
            idx_ok   = 1'b1;
        end
        else
        begin
            ch = r.knob_index;
            if (r.kind == KIND_FREEZE_ALL)
            begin
                frozen_bits = '1;
            end
            else if (idx_ok)
            begin
                case (r.kind)
                    KIND_FREEZE_VALUE:
                    begin
                        pickup_mem[ch]  = r.freeze_value;
                        frozen_bits[ch] = 1'b1;
                    end
                    KIND_FREEZE:   frozen_bits[ch] = 1'b1;
                    KIND_UNFREEZE: frozen_bits[ch] = 1'b0;
                    default:       ;
                endcase
            end
        end
        s.channel = ch;
        if (idx_ok)
        begin
            s.knob_value = knob_mem[ch];
            s.moved      = moved_bits[ch];
            s.frozen     = frozen_bits[ch];
        end
        s.moved_mask  = moved_bits;
        s.frozen_mask = frozen_bits;
        return s;
    endfunction

    // checker, predictor feed and watchdog in one process: results are popped
    // before the request taken on the same edge is pushed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            any_handshake = 1'b0;
            if (result_ch.valid && result_ch.ready)
            begin
                any_handshake = 1'b1;
                seen_status = {result_ch.channel, result_ch.knob_value, result_ch.moved,
                               result_ch.frozen, result_ch.moved_mask, result_ch.frozen_mask};
                if (pending_status.size() == 0)
                begin
                    note_mismatch("result with no request waiting",
                                  int'(seen_status.channel), 0);
                end
                else
                begin
                    want_status = pending_status.pop_front();
                    if (seen_status.channel !== want_status.channel)
                        note_mismatch("channel", int'(seen_status.channel),
                                      int'(want_status.channel));
                    if (seen_status.knob_value !== want_status.knob_value)
                        note_mismatch("knob_value", int'(seen_status.knob_value),
                                      int'(want_status.knob_value));
                    if (seen_status.moved !== want_status.moved)
                        note_mismatch("moved", int'(seen_status.moved),
                                      int'(want_status.moved));
                    if (seen_status.frozen !== want_status.frozen)
                        note_mismatch("frozen", int'(seen_status.frozen),
                                      int'(want_status.frozen));
                    if (seen_status.moved_mask !== want_status.moved_mask)
                        note_mismatch("moved_mask", int'(seen_status.moved_mask),
                                      int'(want_status.moved_mask));
                    if (seen_status.frozen_mask !== want_status.frozen_mask)
                        note_mismatch("frozen_mask", int'(seen_status.frozen_mask),
                                      int'(want_status.frozen_mask));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                any_handshake = 1'b1;
                taken_req = {item_ch.kind, item_ch.adc_sample, item_ch.knob_index,
                             item_ch.freeze_value};
                want_status = apply_request(taken_req);
                pending_status.push_back(offered_known ? offered_fixed : want_status);
            end
            quiet_cycles = any_handshake ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t ns watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result receiver, with a one-time long hold-off when asked
    initial
    begin : result_sink
        bit hold_taken;
        hold_taken = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input knob_request_t r, input logic known,
                                input knob_status_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= r.kind;
        item_ch.adc_sample   <= r.adc_sample;
        item_ch.knob_index   <= r.knob_index;
        item_ch.freeze_value <= r.freeze_value;
        offered_known        <= known;
        offered_fixed        <= want;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    // park the request channel and wait until every result is back
    task automatic finish_burst();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_status.size() != 0);
    endtask

    task automatic write_tolerance(input logic [VALUE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tolerance_model = value;
    endtask

    function automatic knob_request_t make_request();
        knob_request_t r;
        int            v;
        r.kind         = KIND_SAMPLE;
        r.adc_sample   = SAMPLE_W'($urandom_range(1023));
        r.knob_index   = INDEX_W'($urandom_range(7));
        r.freeze_value = VALUE_W'($urandom_range(255));
        if ($urandom_range(99) < 60)
        begin
            if ($urandom_range(1) == 1)
            begin
                // small step from the last value, to exercise tolerance and pickup edges
                v = int'(walk[gen_scan]) + int'($urandom_range(8)) - 4;
                v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                r.adc_sample = {v[VALUE_W-1:0], 2'($urandom_range(3))};
            end
            walk[gen_scan] = r.adc_sample[SAMPLE_W-1:2];
            gen_scan = (gen_scan == KNOBS - 1) ? 0 : gen_scan + 1;
        end
        else
        begin
            r.kind = KIND_W'($urandom_range(1, 7));
            if (r.knob_index >= KNOBS && $urandom_range(3) != 0)
                r.knob_index = INDEX_W'($urandom_range(KNOBS - 1));
            if (r.kind == KIND_FREEZE_VALUE && r.knob_index < KNOBS && $urandom_range(1) == 1)
            begin
                v = int'(walk[r.knob_index]) + int'($urandom_range(6)) - 3;
                v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                r.freeze_value = v[VALUE_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic [KIND_W-1:0] kind, input int sample, input int idx,
                           input int fval, input logic known, input knob_status_t want);
        table_row_t row;
        row.req.kind         = kind;
        row.req.adc_sample   = sample[SAMPLE_W-1:0];
        row.req.knob_index   = idx[INDEX_W-1:0];
        row.req.freeze_value = fval[VALUE_W-1:0];
        row.known            = known;
        row.want             = want;
        directed_rows.push_back(row);
    endtask

    initial
    begin : stimulus
        table_row_t row;
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_SAMPLE;
        item_ch.adc_sample   = '0;
        item_ch.knob_index   = '0;
        item_ch.freeze_value = '0;
        offered_known        = 1'b0;
        offered_fixed        = '0;
        hold_req             = 1'b0;

        for (int i = 0; i < KNOBS; i++)
        begin
            knob_mem[i]   = '0;
            pickup_mem[i] = '0;
            walk[i]       = '0;
        end
        frozen_bits     = '1;
        moved_bits      = '0;
        scan_pos        = '0;
        tolerance_model = 8'd1;

        // state right after reset, then out-of-range knobs and spare kinds
        add_row(KIND_QUERY,        0,    0, 0,   1'b1, make_status(0, 0, 0, 1, 'h00, 'h3F));
        add_row(KIND_QUERY,        1023, 7, 255, 1'b1, make_status(7, 0, 0, 0, 'h00, 'h3F));
        add_row(KIND_SPARE_HI,     0,    3, 0,   1'b1, make_status(3, 0, 0, 1, 'h00, 'h3F));
        add_row(KIND_SPARE_LO,     0,    6, 0,   1'b1, make_status(6, 0, 0, 0, 'h00, 'h3F));
        // full-scale jump on knob 0, then no change on knob 1 sitting on its pickup
        add_row(KIND_SAMPLE,       1023, 0, 0,   1'b1, make_status(0, 255, 1, 0, 'h01, 'h3E));
        add_row(KIND_SAMPLE,       0,    5, 0,   1'b1, make_status(1, 0, 0, 0, 'h01, 'h3C));
        add_row(KIND_FREEZE_VALUE, 0,    2, 255, 1'b1, make_status(2, 0, 0, 1, 'h01, 'h3C));
        add_row(KIND_SAMPLE,       3,    0, 0,   1'b1, make_status(2, 0, 0, 1, 'h01, 'h3C));
        // change equal to the tolerance is not a move, pickup still crossed
        add_row(KIND_SAMPLE,       4,    0, 0,   1'b1, make_status(3, 1, 0, 0, 'h01, 'h34));
        add_row(KIND_FREEZE,       0,    0, 0,   1'b1, make_status(0, 255, 1, 1, 'h01, 'h35));
        add_row(KIND_UNFREEZE,     0,    5, 0,   1'b1, make_status(5, 0, 0, 0, 'h01, 'h15));
        add_row(KIND_FREEZE_ALL,   0,    4, 0,   1'b1, make_status(4, 0, 0, 1, 'h01, 'h3F));
        add_row(KIND_FREEZE_VALUE, 0,    6, 77,  1'b1, make_status(6, 0, 0, 0, 'h01, 'h3F));
        add_row(KIND_UNFREEZE,     0,    7, 0,   1'b1, make_status(7, 0, 0, 0, 'h01, 'h3F));
        add_row(KIND_SAMPLE,       600,  0, 0,   1'b0, '0);
        add_row(KIND_SAMPLE,       1000, 0, 0,   1'b0, '0);
        add_row(KIND_SAMPLE,       1020, 0, 0,   1'b0, '0);
        add_row(KIND_FREEZE_VALUE, 0,    1, 128, 1'b0, '0);
        add_row(KIND_SAMPLE,       515,  0, 0,   1'b0, '0);
        add_row(KIND_QUERY,        0,    1, 0,   1'b0, '0);
        add_row(KIND_FREEZE_VALUE, 0,    2, 200, 1'b0, '0);
        add_row(KIND_SAMPLE,       801,  0, 0,   1'b0, '0);
        add_row(KIND_SAMPLE,       802,  0, 0,   1'b0, '0);
        add_row(KIND_FREEZE_ALL,   0,    0, 0,   1'b0, '0);
        add_row(KIND_SAMPLE,       514,  0, 0,   1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 81;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.req, row.known, row.want);
        end
        finish_burst();
        // the directed samples left the scan at channel 5 and knob 0 at 255
        for (int i = 0; i < KNOBS; i++)
            walk[i] = knob_mem[i];
        gen_scan = int'(scan_pos);

        // strictest tolerance: every change counts as a move
        write_tolerance(8'd0);
        repeat (BURST_ITEMS) send_request(make_request(), 1'b0, '0);
        finish_burst();

        // widest tolerance: only pickup crossings unfreeze
        send_idle_pct = 81;
        recv_idle_pct = 20;
        write_tolerance(8'd255);
        repeat (BURST_ITEMS) send_request(make_request(), 1'b0, '0);
        finish_burst();

        // back-to-back traffic, starting with a long receiver stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tolerance(VALUE_W'($urandom_range(2, 12)));
        hold_req <= 1'b1;
        repeat (BURST_ITEMS) send_request(make_request(), 1'b0, '0);
        finish_burst();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_status.size() != 0)
            note_mismatch("results never returned", pending_status.size(), 0);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
